// ===== rtl/core/dss_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the diffusion stencil sweep.
// No dependencies; imported by every module of the block.
package dss_pkg;

    localparam int CELL_W      = 32;
    localparam int GRID_W      = 12;
    localparam int GAIN_W      = 23;
    localparam int SUM_W       = 48;
    localparam int FRAC_W      = 24;
    // n+s+e+w-4c needs three bits over one cell
    localparam int LAP_W       = CELL_W + 3;
    localparam int PROD_W      = LAP_W + GAIN_W + 1;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = GAIN_W;

    localparam int MAX_GRID_DEF = 2048;
    localparam int GRID_MIN     = 3;
    localparam int GRID_RESET   = 2048;
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(16777);
    localparam logic [SUM_W-1:0]  SUM_MAX    = '1;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GRID_SIZE      = 2'd0,
        CFG_DIFFUSION_GAIN = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic                     mode;
        logic signed [CELL_W-1:0] cell_value;
    } item_t;

    typedef struct packed {
        logic signed [CELL_W-1:0] new_value;
        logic                     frame_last;
        logic [SUM_W-1:0]         diff_sum;
    } result_t;

    // Per-cell classification made at the front
    typedef struct packed {
        logic have;      // this cell releases a result
        logic interior;  // released cell gets the stencil update
        logic last;      // released cell closes the frame
    } cell_class_t;

    localparam int CLASS_W = $bits(cell_class_t);

endpackage

// ===== rtl/core/dss_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts items, tracks the raster position and classifies each cell.
// Depends on dss_pkg.
module dss_front #(
    parameter int MAX_GRID = dss_pkg::MAX_GRID_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [$clog2(MAX_GRID+1)-1:0]     grid_used,
    input  logic                              restart,
    input  logic                              enable,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  dss_pkg::item_t                    item,
    output logic                              push_valid,
    input  logic                              push_ready,
    output logic signed [dss_pkg::CELL_W-1:0] push_x,
    output logic [$clog2(MAX_GRID)-1:0]       push_col,
    output dss_pkg::cell_class_t              push_cls
);
    import dss_pkg::*;

    localparam int CW = $clog2(MAX_GRID);
    localparam int RW = $clog2(MAX_GRID + 2);
    localparam int PW = RW + 1;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [PW-1:0] g_w, ci_w, ri_w, co_w, ro_w;
    logic          drain, ignore, accept, have, interior, last, wrap;

    always_comb
    begin
        g_w  = PW'(grid_used);
        ci_w = PW'(col_reg);
        if (ci_w >= g_w)
        begin
            ci_w = '0;
        end
        ri_w   = PW'(row_reg);
        drain  = ri_w >= g_w;
        // flush ticks only count once the whole frame is in
        ignore = item.mode && !drain;
        accept = item_valid && item_ready;
        have   = (ri_w >= PW'(2)) || ((ri_w == PW'(1)) && (ci_w != '0));
        if (ci_w == '0)
        begin
            co_w = g_w - PW'(1);
            ro_w = ri_w - PW'(2);
        end
        else
        begin
            co_w = ci_w - PW'(1);
            ro_w = ri_w - PW'(1);
        end
        interior = have && (ro_w >= PW'(1)) && ((ro_w + PW'(2)) <= g_w)
                   && (co_w >= PW'(1)) && ((co_w + PW'(2)) <= g_w);
        last     = have && (ri_w >= PW'(2)) && (ro_w == g_w - PW'(1))
                   && (co_w == g_w - PW'(1));
        wrap     = (ci_w + PW'(1)) >= g_w;

        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept && !ignore)
        begin
            if (last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (wrap)
            begin
                col_next = '0;
                row_next = RW'(ri_w + PW'(1));
            end
            else
            begin
                col_next = CW'(ci_w + PW'(1));
            end
        end
    end

    assign item_ready = push_ready && enable;
    assign push_valid = accept && !ignore;
    assign push_x     = drain ? '0 : item.cell_value;
    assign push_col   = CW'(ci_w);
    assign push_cls   = '{have: have, interior: interior, last: last};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== rtl/core/dss_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO between the front end and the stencil back end.
// Depends on dss_pkg for its depth.
module dss_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         ready,
    output logic         valid,
    output logic [W-1:0] rdata,
    input  logic         pop
);
    import dss_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign ready = count_reg != CNT_W'(DEPTH);
    assign valid = count_reg != '0;
    assign rdata = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/dss_back.sv =====
`timescale 1ns / 1ps
// Back end: line buffers, stencil window, update pipeline and change accumulator.
// Depends on dss_pkg.
module dss_back #(
    parameter int MAX_GRID = dss_pkg::MAX_GRID_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [dss_pkg::GAIN_W-1:0]   gain,
    input  logic                         restart,
    input  logic                         q_valid,
    input  logic [dss_pkg::CELL_W+$clog2(MAX_GRID)+dss_pkg::CLASS_W-1:0] q_data,
    output logic                         q_pop,
    output logic                         init_done,
    output logic                         result_valid,
    input  logic                         result_ready,
    output dss_pkg::result_t             result
);
    import dss_pkg::*;

    localparam int CW = $clog2(MAX_GRID);
    localparam int QW = CELL_W + CW + CLASS_W;
    localparam int SW = LAP_W + 1;
    localparam int DW = CELL_W + 1;
    localparam int AW = SUM_W + 1;

    // line buffers
    logic signed [CELL_W-1:0] rab_mem [MAX_GRID];
    logic signed [CELL_W-1:0] rcb_mem [MAX_GRID];

    logic [CW-1:0] clr_addr_reg;
    logic          init_done_reg;

    logic signed [CELL_W-1:0] q_x;
    logic [CW-1:0]            q_col;
    cell_class_t              q_cls;
    logic                     adv, pop, fwd_hit;

    // stage 1: buffer read data and cell info
    logic                     s1_valid_reg;
    logic signed [CELL_W-1:0] s1_x_reg;
    logic [CW-1:0]            s1_col_reg;
    cell_class_t              s1_cls_reg;
    logic signed [CELL_W-1:0] rcb_rd_reg, rab_rd_reg, fwd_data_reg;
    logic                     fwd_hit_reg;
    logic signed [CELL_W-1:0] s1_rab;

    // window: north, center, south, west
    logic signed [CELL_W-1:0] win_n_reg, win_c_reg, win_s_reg, win_w_reg;
    logic signed [LAP_W-1:0]  lap;

    logic                     s2_valid_reg, s2_interior_reg, s2_last_reg;
    logic signed [LAP_W-1:0]  s2_lap_reg;
    logic signed [CELL_W-1:0] s2_c_reg;
    logic signed [GAIN_W:0]   gain_s;

    logic                     s3_valid_reg, s3_interior_reg, s3_last_reg;
    logic signed [PROD_W-1:0] s3_prod_reg;
    logic signed [CELL_W-1:0] s3_c_reg;
    logic signed [LAP_W-1:0]  step;
    logic signed [SW-1:0]     sum;

    logic                     s4_valid_reg, s4_interior_reg, s4_last_reg;
    logic signed [SW-1:0]     s4_sum_reg;
    logic signed [CELL_W-1:0] s4_c_reg;
    logic signed [CELL_W-1:0] nv;
    logic signed [DW-1:0]     d;

    logic                     s5_valid_reg, s5_interior_reg, s5_last_reg;
    logic signed [CELL_W-1:0] s5_nv_reg;
    logic signed [DW-1:0]     s5_d_reg;
    logic                     neg;
    logic [DW-1:0]            mag;
    logic [AW-1:0]            acc_sum;
    logic [SUM_W-1:0]         acc_sat, acc_new, acc_reg;

    logic                     result_valid_reg;
    result_t                  result_reg;

    assign q_x   = q_data[QW-1 -: CELL_W];
    assign q_col = q_data[CLASS_W +: CW];
    assign q_cls = cell_class_t'(q_data[CLASS_W-1:0]);

    // whole pipeline moves together; output register is the only stall point
    assign adv     = !result_valid_reg || result_ready;
    assign pop     = adv && q_valid && init_done_reg;
    assign q_pop   = pop;
    assign fwd_hit = s1_valid_reg && (s1_col_reg == q_col);
    assign s1_rab  = fwd_hit_reg ? fwd_data_reg : rab_rd_reg;

    assign init_done    = init_done_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // center buffer: read-first, written with the incoming cell
    always_ff @(posedge clk)
    begin
        if (!init_done_reg)
        begin
            rcb_mem[clr_addr_reg] <= '0;
        end
        else if (pop)
        begin
            rcb_mem[q_col] <= q_x;
        end
        if (pop)
        begin
            rcb_rd_reg <= rcb_mem[q_col];
        end
    end

    // above buffer: takes the old center word in the following cycle
    always_ff @(posedge clk)
    begin
        if (!init_done_reg)
        begin
            rab_mem[clr_addr_reg] <= '0;
        end
        else if (s1_valid_reg)
        begin
            rab_mem[s1_col_reg] <= rcb_rd_reg;
        end
        if (pop)
        begin
            rab_rd_reg <= rab_mem[q_col];
        end
    end

    always_comb
    begin
        lap = LAP_W'(win_n_reg) + LAP_W'(win_s_reg) + LAP_W'(rcb_rd_reg)
              + LAP_W'(win_w_reg) - (LAP_W'(win_c_reg) <<< 2);
        gain_s = $signed({1'b0, gain});
        step   = $signed(s3_prod_reg[PROD_W-1:FRAC_W]);
        sum    = s3_interior_reg ? (SW'(s3_c_reg) + SW'(step)) : SW'(s3_c_reg);
        if ((s4_sum_reg[SW-1:CELL_W-1] != '0) && (s4_sum_reg[SW-1:CELL_W-1] != '1))
        begin
            nv = s4_sum_reg[SW-1] ? {1'b1, {(CELL_W-1){1'b0}}} : {1'b0, {(CELL_W-1){1'b1}}};
        end
        else
        begin
            nv = s4_sum_reg[CELL_W-1:0];
        end
        d       = DW'(nv) - DW'(s4_c_reg);
        neg     = s5_d_reg[DW-1];
        mag     = neg ? ~s5_d_reg : s5_d_reg;
        acc_sum = AW'(acc_reg) + AW'(mag) + AW'(neg);
        acc_sat = acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
        acc_new = s5_interior_reg ? acc_sat : acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg     <= '0;
            init_done_reg    <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            s5_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            win_n_reg        <= '0;
            win_c_reg        <= '0;
            win_s_reg        <= '0;
            win_w_reg        <= '0;
            acc_reg          <= '0;
        end
        else
        begin
            if (!init_done_reg)
            begin
                clr_addr_reg <= clr_addr_reg + CW'(1);
                if (clr_addr_reg == CW'(MAX_GRID - 1))
                begin
                    init_done_reg <= 1'b1;
                end
            end
            if (adv)
            begin
                s1_valid_reg     <= pop;
                s2_valid_reg     <= s1_valid_reg && s1_cls_reg.have;
                s3_valid_reg     <= s2_valid_reg;
                s4_valid_reg     <= s3_valid_reg;
                s5_valid_reg     <= s4_valid_reg;
                result_valid_reg <= s5_valid_reg;
            end
            if (adv && s1_valid_reg)
            begin
                win_w_reg <= win_c_reg;
                win_n_reg <= s1_rab;
                win_c_reg <= rcb_rd_reg;
                win_s_reg <= s1_x_reg;
            end
            if (restart)
            begin
                acc_reg <= '0;
            end
            else if (adv && s5_valid_reg)
            begin
                acc_reg <= s5_last_reg ? '0 : acc_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_x_reg     <= q_x;
            s1_col_reg   <= q_col;
            s1_cls_reg   <= q_cls;
            fwd_hit_reg  <= fwd_hit;
            fwd_data_reg <= rcb_rd_reg;
        end
        if (adv)
        begin
            s2_lap_reg      <= lap;
            s2_c_reg        <= win_c_reg;
            s2_interior_reg <= s1_cls_reg.interior;
            s2_last_reg     <= s1_cls_reg.last;

            s3_prod_reg     <= PROD_W'(s2_lap_reg) * PROD_W'(gain_s);
            s3_c_reg        <= s2_c_reg;
            s3_interior_reg <= s2_interior_reg;
            s3_last_reg     <= s2_last_reg;

            s4_sum_reg      <= sum;
            s4_c_reg        <= s3_c_reg;
            s4_interior_reg <= s3_interior_reg;
            s4_last_reg     <= s3_last_reg;

            s5_nv_reg       <= nv;
            s5_d_reg        <= d;
            s5_interior_reg <= s4_interior_reg;
            s5_last_reg     <= s4_last_reg;
        end
        if (adv && s5_valid_reg)
        begin
            result_reg.new_value  <= s5_nv_reg;
            result_reg.frame_last <= s5_last_reg;
            result_reg.diff_sum   <= s5_last_reg ? acc_new : '0;
        end
    end

endmodule

// ===== rtl/core/diffusion_stencil_sweep_top.sv =====
`timescale 1ns / 1ps
// Top level of the five-point diffusion stencil sweep.
// Depends on dss_pkg, dss_front, dss_queue and dss_back.
//
//  port group | dir | handshake                 | payload
//  -----------+-----+---------------------------+-----------------------------------
//  item       | in  | item_valid / item_ready   | dss_pkg::item_t  (mode, cell_value)
//  result     | out | result_valid/result_ready | dss_pkg::result_t (new_value, ...)
//  cfg        | in  | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
//  One item per cycle sustained unless the output stalls; a result passes through the
//  queue, stages s1 to s5 and the output register. After reset both line buffers are
//  zeroed one word per cycle with item_ready low. Config writes are taken at any time
//  (cfg_ready is tied high). A stalled result holds the back pipeline; the 4-entry queue
//  keeps item_ready high until it fills, then item_ready drops.
module diffusion_stencil_sweep_top #(
    parameter int MAX_GRID = dss_pkg::MAX_GRID_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  dss_pkg::item_t                   item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output dss_pkg::result_t                 result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dss_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [dss_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dss_pkg::*;

    localparam int GW  = $clog2(MAX_GRID + 1);
    localparam int CW  = $clog2(MAX_GRID);
    localparam int QW  = CELL_W + CW + CLASS_W;
    localparam int CLW = (GW > GRID_W) ? GW : GRID_W;
    localparam logic [GW-1:0] GRID_RST = GW'((GRID_RESET > MAX_GRID) ? MAX_GRID : GRID_RESET);

    // Config registers. The grid size is kept already clamped to [3, MAX_GRID].
    logic [GW-1:0]     grid_used_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [CLW-1:0]    grid_ext, grid_clamped;
    logic              cfg_fire, restart;

    // front -> queue -> back
    logic                     push_valid, q_ready, q_valid, q_pop, init_done;
    logic signed [CELL_W-1:0] push_x;
    logic [CW-1:0]            push_col;
    cell_class_t              push_cls;
    logic [QW-1:0]            q_data;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    // a grid size write restarts the frame: position counters and running sum clear
    assign restart   = cfg_fire && (cfg_reg_t'(cfg_index) == CFG_GRID_SIZE);

    always_comb
    begin
        grid_ext = CLW'(cfg_data[GRID_W-1:0]);
        if (grid_ext < CLW'(GRID_MIN))
        begin
            grid_clamped = CLW'(GRID_MIN);
        end
        else if (grid_ext > CLW'(MAX_GRID))
        begin
            grid_clamped = CLW'(MAX_GRID);
        end
        else
        begin
            grid_clamped = grid_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_used_reg <= GRID_RST;
            gain_reg      <= GAIN_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_GRID_SIZE:      grid_used_reg <= GW'(grid_clamped);
                CFG_DIFFUSION_GAIN: gain_reg      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Front end: raster position, flush filtering, boundary/interior/last tagging.
    dss_front #(
        .MAX_GRID (MAX_GRID)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .grid_used  (grid_used_reg),
        .restart    (restart),
        .enable     (init_done),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (q_ready),
        .push_x     (push_x),
        .push_col   (push_col),
        .push_cls   (push_cls)
    );

    // Decoupling queue between classification and the stencil pipeline.
    dss_queue #(
        .W (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push_valid),
        .wdata ({push_x, push_col, push_cls}),
        .ready (q_ready),
        .valid (q_valid),
        .rdata (q_data),
        .pop   (q_pop)
    );

    // Back end: two line buffers, north/center/south/west window, multiply, saturate, accumulate.
    dss_back #(
        .MAX_GRID (MAX_GRID)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .gain         (gain_reg),
        .restart      (restart),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .init_done    (init_done),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // No item may enter while the line buffers are still being zeroed.
    a_no_item_during_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        !init_done |-> !item_ready
    ) else $error("item_ready high during line buffer clear");

    // The front end never pushes into a full queue.
    a_queue_no_overflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        push_valid |-> q_ready
    ) else $error("push into full queue");

    // The running sum is only reported on the frame's final cell.
    a_sum_only_on_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && !result.frame_last) |-> (result.diff_sum == '0)
    ) else $error("diff_sum nonzero outside frame end");

endmodule
